### rtl/edc_pkg.sv
// Shared types, widths and helpers for the elastic disk collision block.
`timescale 1ns / 1ps

package edc_pkg;

    localparam int PAIR_W      = 318;
    localparam int IN_TDATA_W  = 320;
    localparam int OUT_TDATA_W = 256;
    localparam int MARGIN_W    = 16;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd66;

    localparam logic signed [37:0] S32_MAX = 38'sd2147483647;
    localparam logic signed [37:0] S32_MIN = -38'sd2147483648;

    // Input item, first field in the lowest bits.
    typedef struct packed {
        logic [30:0]        b_radius;
        logic signed [31:0] b_vy;
        logic signed [31:0] b_vx;
        logic signed [31:0] b_y;
        logic signed [31:0] b_x;
        logic [30:0]        a_radius;
        logic signed [31:0] a_vy;
        logic signed [31:0] a_vx;
        logic signed [31:0] a_y;
        logic signed [31:0] a_x;
    } pair_t;

    // Result item without the collided flag, first field in the lowest bits.
    typedef struct packed {
        logic signed [31:0] new_b_vy;
        logic signed [31:0] new_b_vx;
        logic signed [31:0] new_b_y;
        logic signed [31:0] new_b_x;
        logic signed [31:0] new_a_vy;
        logic signed [31:0] new_a_vx;
        logic signed [31:0] new_a_y;
        logic signed [31:0] new_a_x;
    } result_t;

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
        logic signed [37:0] c;
        begin
            c = x;
            if (x > S32_MAX) begin
                c = S32_MAX;
            end else if (x < S32_MIN) begin
                c = S32_MIN;
            end
            return c[31:0];
        end
    endfunction

endpackage

### rtl/elastic_disk_collision.sv
// Top level: pipelined equal-mass elastic collision of two disks.
`timescale 1ns / 1ps

// Usage
//   s_t* carries one item per disk pair (positions, velocities, radii); m_t*
//   returns one item per pair: new positions and velocities in m_tdata and the
//   collided flag in m_tuser. cfg_* writes separation_margin; cfg_ready is
//   always high, and a write belongs to an idle block.
// Stages: 3 setup stages, 32 square-root stages, FRAC_BITS + 1 divider stages,
//   3 multiply stages and the output register lie between input accept and
//   result valid.
// Throughput: one item per cycle while m_tready holds high; every stage holds
//   one item, so the square root and the two dividers each retire one bit per stage.
// Stall: each stage loads when it is empty or its successor loads, so bubbles
//   are squeezed out and a stalled result never blocks items still in flight
//   until the whole pipeline is full; then s_tready drops.
// Reset: all valid bits clear, separation_margin returns to 66.
module elastic_disk_collision #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // a_x, a_y, a_vx, a_vy, a_radius, b_x, b_y, b_vx, b_vy, b_radius
    input  logic [edc_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // new_a_x, new_a_y, new_a_vx, new_a_vy, new_b_x, new_b_y, new_b_vx, new_b_vy
    output logic [edc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // collided
    output logic                               m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [edc_pkg::MARGIN_W-1:0]       cfg_data
);
    import edc_pkg::*;

    localparam int SQ_STEPS = 32;
    localparam int QW = FRAC_BITS + 1;   // quotient bits of |n|
    localparam int NW = FRAC_BITS + 2;   // signed normal component
    localparam int PW = 32 + NW;         // velocity x normal
    localparam int SW = 34 + NW;         // push distance x normal
    localparam int TW = 35 + NW;         // velocity component x normal

    localparam logic signed [NW-1:0] N_ONE  = {2'b01, {FRAC_BITS{1'b0}}};
    localparam logic signed [NW-1:0] N_MONE = -N_ONE;

    typedef struct packed {
        pair_t       base;
        logic        dxn;
        logic        dyn;
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] sumr;
    } st1_t;

    typedef struct packed {
        pair_t       base;
        logic        dxn;
        logic        dyn;
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] sumr;
        logic [63:0] sx2;
        logic [63:0] sy2;
        logic [63:0] sumr2;
    } st2_t;

    typedef struct packed {
        pair_t       base;
        logic        dxn;
        logic        dyn;
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] sumr;
        logic [63:0] dist2;
        logic        coll;
    } st3_t;

    typedef struct packed {
        pair_t       base;
        logic        dxn;
        logic        dyn;
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] sumr;
        logic        coll;
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sq_t;

    typedef struct packed {
        pair_t         base;
        logic          dxn;
        logic          dyn;
        logic [31:0]   sumr;
        logic          coll;
        logic [31:0]   dlen;
        logic [31:0]   remx;
        logic [31:0]   remy;
        logic [QW-1:0] qx;
        logic [QW-1:0] qy;
    } dv_t;

    typedef struct packed {
        pair_t                base;
        logic                 coll;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [PW-1:0] avx_nx;
        logic signed [PW-1:0] avy_ny;
        logic signed [PW-1:0] avy_nx;
        logic signed [PW-1:0] avx_ny;
        logic signed [PW-1:0] bvx_nx;
        logic signed [PW-1:0] bvy_ny;
        logic signed [PW-1:0] bvy_nx;
        logic signed [PW-1:0] bvx_ny;
        logic signed [33:0]   sep;
    } p1_t;

    typedef struct packed {
        pair_t                base;
        logic                 coll;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [34:0]   v1n;
        logic signed [34:0]   v1t;
        logic signed [34:0]   v2n;
        logic signed [34:0]   v2t;
        logic signed [SW-1:0] sep_nx;
        logic signed [SW-1:0] sep_ny;
    } p2_t;

    typedef struct packed {
        pair_t                base;
        logic                 coll;
        logic signed [TW-1:0] v2n_nx;
        logic signed [TW-1:0] v1t_ny;
        logic signed [TW-1:0] v2n_ny;
        logic signed [TW-1:0] v1t_nx;
        logic signed [TW-1:0] v1n_nx;
        logic signed [TW-1:0] v2t_ny;
        logic signed [TW-1:0] v1n_ny;
        logic signed [TW-1:0] v2t_nx;
        logic signed [35:0]   px;
        logic signed [35:0]   py;
    } p3_t;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [MARGIN_W-1:0] margin_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg <= MARGIN_RESET;
        end else if (cfg_valid) begin
            margin_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage registers and the ready chain (a stage loads when it is empty
    // or its successor loads)
    // ------------------------------------------------------------------
    st1_t st1_reg, st1_next;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    sq_t  sq_reg  [SQ_STEPS];
    sq_t  sq_next [SQ_STEPS];
    sq_t  sq_src  [SQ_STEPS+1];
    dv_t  dv_reg  [QW];
    dv_t  dv_next [QW];
    p1_t  p1_reg, p1_next;
    p2_t  p2_reg, p2_next;
    p3_t  p3_reg, p3_next;
    result_t m_data_reg, m_data_next;
    logic    m_coll_reg, m_coll_next;

    logic st1_vld_reg, st2_vld_reg, st3_vld_reg;
    logic sq_vld_reg [SQ_STEPS];
    logic sq_src_vld [SQ_STEPS+1];
    logic dv_vld_reg [QW];
    logic p1_vld_reg, p2_vld_reg, p3_vld_reg, m_vld_reg;

    logic st1_rdy, st2_rdy, st3_rdy, p1_rdy, p2_rdy, p3_rdy, out_rdy;
    logic sq_rdy [SQ_STEPS+1];
    logic dv_rdy [QW+1];

    assign out_rdy = !m_vld_reg || m_tready;
    assign p3_rdy  = !p3_vld_reg || out_rdy;
    assign p2_rdy  = !p2_vld_reg || p3_rdy;
    assign p1_rdy  = !p1_vld_reg || p2_rdy;
    assign dv_rdy[QW]       = p1_rdy;
    assign sq_rdy[SQ_STEPS] = dv_rdy[0];
    assign st3_rdy = !st3_vld_reg || sq_rdy[0];
    assign st2_rdy = !st2_vld_reg || st3_rdy;
    assign st1_rdy = !st1_vld_reg || st2_rdy;
    assign s_tready = st1_rdy;

    // ------------------------------------------------------------------
    // Stage 1: center offsets as sign and magnitude, radius sum
    // ------------------------------------------------------------------
    pair_t in_pair;
    assign in_pair = pair_t'(s_tdata[PAIR_W-1:0]);

    always_comb begin
        st1_next.base = in_pair;
        st1_next.dxn  = in_pair.b_x < in_pair.a_x;
        st1_next.dyn  = in_pair.b_y < in_pair.a_y;
        st1_next.ux   = st1_next.dxn ? 32'(in_pair.a_x - in_pair.b_x)
                                     : 32'(in_pair.b_x - in_pair.a_x);
        st1_next.uy   = st1_next.dyn ? 32'(in_pair.a_y - in_pair.b_y)
                                     : 32'(in_pair.b_y - in_pair.a_y);
        st1_next.sumr = {1'b0, in_pair.a_radius} + {1'b0, in_pair.b_radius};
    end

    // Stage 2: squares
    always_comb begin
        st2_next.base  = st1_reg.base;
        st2_next.dxn   = st1_reg.dxn;
        st2_next.dyn   = st1_reg.dyn;
        st2_next.ux    = st1_reg.ux;
        st2_next.uy    = st1_reg.uy;
        st2_next.sumr  = st1_reg.sumr;
        st2_next.sx2   = 64'(st1_reg.ux) * 64'(st1_reg.ux);
        st2_next.sy2   = 64'(st1_reg.uy) * 64'(st1_reg.uy);
        st2_next.sumr2 = 64'(st1_reg.sumr) * 64'(st1_reg.sumr);
    end

    // Stage 3: squared distance and the overlap test; a carry out means far
    logic [64:0] dist2_sum;
    always_comb begin
        dist2_sum      = {1'b0, st2_reg.sx2} + {1'b0, st2_reg.sy2};
        st3_next.base  = st2_reg.base;
        st3_next.dxn   = st2_reg.dxn;
        st3_next.dyn   = st2_reg.dyn;
        st3_next.ux    = st2_reg.ux;
        st3_next.uy    = st2_reg.uy;
        st3_next.sumr  = st2_reg.sumr;
        st3_next.dist2 = dist2_sum[63:0];
        st3_next.coll  = !dist2_sum[64] && (dist2_sum[63:0] <= st2_reg.sumr2)
                         && (dist2_sum[63:0] != 64'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_vld_reg <= 1'b0;
            st2_vld_reg <= 1'b0;
            st3_vld_reg <= 1'b0;
        end else begin
            if (st1_rdy) begin
                st1_vld_reg <= s_tvalid;
            end
            if (st2_rdy) begin
                st2_vld_reg <= st1_vld_reg;
            end
            if (st3_rdy) begin
                st3_vld_reg <= st2_vld_reg;
            end
        end
        if (st1_rdy) begin
            st1_reg <= st1_next;
        end
        if (st2_rdy) begin
            st2_reg <= st2_next;
        end
        if (st3_rdy) begin
            st3_reg <= st3_next;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one root bit per stage, radicand consumed two bits a stage
    // ------------------------------------------------------------------
    always_comb begin
        sq_src[0].base = st3_reg.base;
        sq_src[0].dxn  = st3_reg.dxn;
        sq_src[0].dyn  = st3_reg.dyn;
        sq_src[0].ux   = st3_reg.ux;
        sq_src[0].uy   = st3_reg.uy;
        sq_src[0].sumr = st3_reg.sumr;
        sq_src[0].coll = st3_reg.coll;
        sq_src[0].rad  = st3_reg.dist2;
        sq_src[0].rem  = 34'd0;
        sq_src[0].root = 32'd0;
    end
    assign sq_src_vld[0] = st3_vld_reg;

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        logic [35:0] cat;
        logic [35:0] trial;

        assign sq_rdy[j]         = !sq_vld_reg[j] || sq_rdy[j+1];
        assign sq_src[j+1]       = sq_reg[j];
        assign sq_src_vld[j+1]   = sq_vld_reg[j];

        always_comb begin
            cat        = {sq_src[j].rem, sq_src[j].rad[63:62]};
            trial      = cat - {2'b00, sq_src[j].root, 2'b01};
            sq_next[j] = sq_src[j];
            sq_next[j].rad = {sq_src[j].rad[61:0], 2'b00};
            if (!trial[35]) begin
                sq_next[j].rem  = trial[33:0];
                sq_next[j].root = {sq_src[j].root[30:0], 1'b1};
            end else begin
                sq_next[j].rem  = cat[33:0];
                sq_next[j].root = {sq_src[j].root[30:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[j] <= 1'b0;
            end else if (sq_rdy[j]) begin
                sq_vld_reg[j] <= sq_src_vld[j];
            end
            if (sq_rdy[j]) begin
                sq_reg[j] <= sq_next[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Dividers: |d| * 2^FRAC_BITS / root for both axes, MSB of the quotient
    // first; |d| <= root keeps the quotient within FRAC_BITS + 1 bits
    // ------------------------------------------------------------------
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [32:0] rx;
        logic [32:0] ry;
        logic        gx;
        logic        gy;
        logic [32:0] dx_sub;
        logic [32:0] dy_sub;
        dv_t         src;
        logic        src_vld;

        assign dv_rdy[k] = !dv_vld_reg[k] || dv_rdy[k+1];

        if (k == 0) begin : g_first
            always_comb begin
                src.base = sq_reg[SQ_STEPS-1].base;
                src.dxn  = sq_reg[SQ_STEPS-1].dxn;
                src.dyn  = sq_reg[SQ_STEPS-1].dyn;
                src.sumr = sq_reg[SQ_STEPS-1].sumr;
                src.coll = sq_reg[SQ_STEPS-1].coll;
                src.dlen = sq_reg[SQ_STEPS-1].root;
                src.remx = 32'd0;
                src.remy = 32'd0;
                src.qx   = '0;
                src.qy   = '0;
                rx       = {1'b0, sq_reg[SQ_STEPS-1].ux};
                ry       = {1'b0, sq_reg[SQ_STEPS-1].uy};
            end
            assign src_vld = sq_vld_reg[SQ_STEPS-1];
        end else begin : g_next
            always_comb begin
                src = dv_reg[k-1];
                rx  = {dv_reg[k-1].remx, 1'b0};
                ry  = {dv_reg[k-1].remy, 1'b0};
            end
            assign src_vld = dv_vld_reg[k-1];
        end

        always_comb begin
            gx         = rx >= {1'b0, src.dlen};
            gy         = ry >= {1'b0, src.dlen};
            dx_sub     = rx - {1'b0, src.dlen};
            dy_sub     = ry - {1'b0, src.dlen};
            dv_next[k] = src;
            dv_next[k].remx = gx ? dx_sub[31:0] : rx[31:0];
            dv_next[k].remy = gy ? dy_sub[31:0] : ry[31:0];
            dv_next[k].qx   = {src.qx[QW-2:0], gx};
            dv_next[k].qy   = {src.qy[QW-2:0], gy};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[k] <= 1'b0;
            end else if (dv_rdy[k]) begin
                dv_vld_reg[k] <= src_vld;
            end
            if (dv_rdy[k]) begin
                dv_reg[k] <= dv_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // P1: signed normal, first velocity products, half push distance
    // ------------------------------------------------------------------
    dv_t                  dvl;
    logic signed [NW-1:0] nx_w;
    logic signed [NW-1:0] ny_w;
    logic [33:0]          sep_sum;

    assign dvl = dv_reg[QW-1];

    always_comb begin
        nx_w    = dvl.dxn ? -$signed({1'b0, dvl.qx}) : $signed({1'b0, dvl.qx});
        ny_w    = dvl.dyn ? -$signed({1'b0, dvl.qy}) : $signed({1'b0, dvl.qy});
        // radius sum never falls below the root when the disks overlap
        sep_sum = {2'b00, dvl.sumr} - {2'b00, dvl.dlen} + {18'd0, margin_reg};

        p1_next.base   = dvl.base;
        p1_next.coll   = dvl.coll;
        p1_next.nx     = nx_w;
        p1_next.ny     = ny_w;
        p1_next.avx_nx = dvl.base.a_vx * nx_w;
        p1_next.avy_ny = dvl.base.a_vy * ny_w;
        p1_next.avy_nx = dvl.base.a_vy * nx_w;
        p1_next.avx_ny = dvl.base.a_vx * ny_w;
        p1_next.bvx_nx = dvl.base.b_vx * nx_w;
        p1_next.bvy_ny = dvl.base.b_vy * ny_w;
        p1_next.bvy_nx = dvl.base.b_vy * nx_w;
        p1_next.bvx_ny = dvl.base.b_vx * ny_w;
        p1_next.sep    = $signed({1'b0, sep_sum[33:1]});
    end

    // P2: normal and tangential components (floor shift), push products
    logic signed [PW:0] s_v1n, s_v1t, s_v2n, s_v2t;
    always_comb begin
        s_v1n = p1_reg.avx_nx + p1_reg.avy_ny;
        s_v1t = p1_reg.avy_nx - p1_reg.avx_ny;
        s_v2n = p1_reg.bvx_nx + p1_reg.bvy_ny;
        s_v2t = p1_reg.bvy_nx - p1_reg.bvx_ny;

        p2_next.base   = p1_reg.base;
        p2_next.coll   = p1_reg.coll;
        p2_next.nx     = p1_reg.nx;
        p2_next.ny     = p1_reg.ny;
        p2_next.v1n    = s_v1n[PW:FRAC_BITS];
        p2_next.v1t    = s_v1t[PW:FRAC_BITS];
        p2_next.v2n    = s_v2n[PW:FRAC_BITS];
        p2_next.v2t    = s_v2t[PW:FRAC_BITS];
        p2_next.sep_nx = p1_reg.sep * p1_reg.nx;
        p2_next.sep_ny = p1_reg.sep * p1_reg.ny;
    end

    // P3: swapped-normal products, push offsets
    always_comb begin
        p3_next.base   = p2_reg.base;
        p3_next.coll   = p2_reg.coll;
        p3_next.v2n_nx = p2_reg.v2n * p2_reg.nx;
        p3_next.v1t_ny = p2_reg.v1t * p2_reg.ny;
        p3_next.v2n_ny = p2_reg.v2n * p2_reg.ny;
        p3_next.v1t_nx = p2_reg.v1t * p2_reg.nx;
        p3_next.v1n_nx = p2_reg.v1n * p2_reg.nx;
        p3_next.v2t_ny = p2_reg.v2t * p2_reg.ny;
        p3_next.v1n_ny = p2_reg.v1n * p2_reg.ny;
        p3_next.v2t_nx = p2_reg.v2t * p2_reg.nx;
        p3_next.px     = p2_reg.sep_nx[SW-1:FRAC_BITS];
        p3_next.py     = p2_reg.sep_ny[SW-1:FRAC_BITS];
    end

    // Output: rebuild velocities, move positions, saturate, pick pass-through
    logic signed [TW:0] t_avx, t_avy, t_bvx, t_bvy;
    logic signed [36:0] pax, pay, pbx, pby;
    always_comb begin
        t_avx = p3_reg.v2n_nx - p3_reg.v1t_ny;
        t_avy = p3_reg.v2n_ny + p3_reg.v1t_nx;
        t_bvx = p3_reg.v1n_nx - p3_reg.v2t_ny;
        t_bvy = p3_reg.v1n_ny + p3_reg.v2t_nx;
        pax   = p3_reg.base.a_x - p3_reg.px;
        pay   = p3_reg.base.a_y - p3_reg.py;
        pbx   = p3_reg.base.b_x + p3_reg.px;
        pby   = p3_reg.base.b_y + p3_reg.py;

        m_coll_next = p3_reg.coll;
        if (p3_reg.coll) begin
            m_data_next.new_a_x  = sat32(38'(pax));
            m_data_next.new_a_y  = sat32(38'(pay));
            m_data_next.new_b_x  = sat32(38'(pbx));
            m_data_next.new_b_y  = sat32(38'(pby));
            m_data_next.new_a_vx = sat32(t_avx[TW:FRAC_BITS]);
            m_data_next.new_a_vy = sat32(t_avy[TW:FRAC_BITS]);
            m_data_next.new_b_vx = sat32(t_bvx[TW:FRAC_BITS]);
            m_data_next.new_b_vy = sat32(t_bvy[TW:FRAC_BITS]);
        end else begin
            m_data_next.new_a_x  = p3_reg.base.a_x;
            m_data_next.new_a_y  = p3_reg.base.a_y;
            m_data_next.new_b_x  = p3_reg.base.b_x;
            m_data_next.new_b_y  = p3_reg.base.b_y;
            m_data_next.new_a_vx = p3_reg.base.a_vx;
            m_data_next.new_a_vy = p3_reg.base.a_vy;
            m_data_next.new_b_vx = p3_reg.base.b_vx;
            m_data_next.new_b_vy = p3_reg.base.b_vy;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else begin
            if (p1_rdy) begin
                p1_vld_reg <= dv_vld_reg[QW-1];
            end
            if (p2_rdy) begin
                p2_vld_reg <= p1_vld_reg;
            end
            if (p3_rdy) begin
                p3_vld_reg <= p2_vld_reg;
            end
            if (out_rdy) begin
                m_vld_reg <= p3_vld_reg;
            end
        end
        if (p1_rdy) begin
            p1_reg <= p1_next;
        end
        if (p2_rdy) begin
            p2_reg <= p2_next;
        end
        if (p3_rdy) begin
            p3_reg <= p3_next;
        end
        if (out_rdy) begin
            m_data_reg <= m_data_next;
            m_coll_reg <= m_coll_next;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_coll_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Input backpressure only when every stage is full and the output stalls.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the pipeline had room");

    // The divided x normal component never exceeds one in magnitude.
    a_normal_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_vld_reg && p1_reg.coll) |-> (p1_reg.nx <= N_ONE && p1_reg.nx >= N_MONE))
        else $error("normal component out of range");

    // Nothing is presented in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule
